// ----- rtl/core/rpq_pkg.sv -----
// Shared types and constants for the range predecessor query unit.
// No dependencies; imported by the controller, the datapath and the top level.
package rpq_pkg;

  // Table geometry and field widths
  localparam int TABLE_SIZE = 1024;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int POS_W      = 11;
  localparam int VALUE_BITS = 20;

  // Request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_REPORT
  } rpq_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic start_query;  // latch clamped bounds, clear best match
    logic step;         // read entry at the scan pointer and advance it
  } rpq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;        // clamped range holds no positions
    logic last;         // scan pointer is at the upper bound
    logic cmp_pending;  // a read is still waiting for its compare
  } rpq_status_t;

endpackage

// ----- rtl/core/rpq_datapath.sv -----
// Datapath of the range predecessor query unit: value table, scan pointer,
// compare stage and best-match registers. Depends on rpq_pkg.
module rpq_datapath import rpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_we_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [POS_W-1:0]      range_low_i,
  input  logic [POS_W-1:0]      range_high_i,
  input  logic [VALUE_BITS-1:0] limit_i,
  input  rpq_cmd_t              cmd_i,
  output rpq_status_t           status_o,
  output logic [POS_W-1:0]      best_position_o,
  output logic                  found_o
);

  logic [VALUE_BITS-1:0] mem [TABLE_SIZE];

  logic [POS_W-1:0]      lo_clamp, hi_clamp;
  logic [POS_W-1:0]      cur_q, hi_q;
  logic                  lo_gt_hi_q;
  logic [VALUE_BITS-1:0] lim_q;
  logic [VALUE_BITS-1:0] rd_data_q;
  logic [POS_W-1:0]      cmp_pos_q;
  logic                  cmp_vld_q;
  logic [VALUE_BITS-1:0] best_val_q, best_val_d;
  logic [POS_W-1:0]      best_pos_q, best_pos_d;
  logic                  hit_q, hit_d;
  logic [POS_W-1:0]      wr_idx, rd_idx;
  logic                  wr_in_range;

  // Clamp query bounds to the table
  always_comb begin
    lo_clamp = (range_low_i == '0) ? POS_W'(1) : range_low_i;
    hi_clamp = (range_high_i > POS_W'(TABLE_SIZE)) ? POS_W'(TABLE_SIZE) : range_high_i;
  end

  // Position to address: positions are one-based
  assign wr_idx      = position_i - POS_W'(1);
  assign rd_idx      = cur_q - POS_W'(1);
  assign wr_in_range = (position_i != '0) && (position_i <= POS_W'(TABLE_SIZE));

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (load_we_i && wr_in_range) begin
      mem[wr_idx[ADDR_W-1:0]] <= value_i;
    end
    if (cmd_i.step) begin
      rd_data_q <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  // Hold query bounds and advance the scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_query) begin
      cur_q      <= lo_clamp;
      hi_q       <= hi_clamp;
      lo_gt_hi_q <= lo_clamp > hi_clamp;
      lim_q      <= limit_i;
    end else if (cmd_i.step) begin
      cur_q <= cur_q + POS_W'(1);
    end
    if (cmd_i.step) begin
      cmp_pos_q <= cur_q;
    end
  end

  // Track which read is waiting for its compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.step;
    end
  end

  // Compare the read entry against the limit and the best so far; ties go high
  always_comb begin
    best_val_d = best_val_q;
    best_pos_d = best_pos_q;
    hit_d      = hit_q;
    if (cmd_i.start_query) begin
      best_pos_d = '0;
      hit_d      = 1'b0;
    end else if (cmp_vld_q && (rd_data_q <= lim_q) &&
                 (!hit_q || (rd_data_q >= best_val_q))) begin
      best_val_d = rd_data_q;
      best_pos_d = cmp_pos_q;
      hit_d      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      best_pos_q <= '0;
    end else begin
      hit_q      <= hit_d;
      best_pos_q <= best_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
  end

  assign status_o.empty       = lo_gt_hi_q;
  assign status_o.last        = (cur_q == hi_q);
  assign status_o.cmp_pending = cmp_vld_q;

  assign best_position_o = best_pos_q;
  assign found_o         = hit_q;

endmodule

// ----- rtl/core/rpq_ctrl.sv -----
// Controller of the range predecessor query unit: sequences the scan of a
// query and issues the result strobe. Depends on rpq_pkg.
module rpq_ctrl import rpq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        req_type_i,
  input  rpq_status_t status_i,
  output rpq_cmd_t    cmd_o,
  output logic        load_we_o,
  output logic        busy_o,
  output logic        result_valid_o
);

  rpq_state_e state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_QUERY)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = status_i.empty ? ST_REPORT : ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.last) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        // wait for the last compare to land
        if (!status_i.cmp_pending) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs
  always_comb begin
    cmd_o.start_query = 1'b0;
    cmd_o.step        = 1'b0;
    load_we_o         = 1'b0;
    result_valid_o    = 1'b0;
    busy_o            = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o            = 1'b0;
        cmd_o.start_query = accept && (req_type_i == REQ_QUERY);
        load_we_o         = accept && (req_type_i == REQ_LOAD);
      end
      ST_CHECK: begin
        // hold the pointer while the latched bounds are checked
        cmd_o.step = 1'b0;
      end
      ST_SCAN: begin
        // read every position up to and including the upper bound
        cmd_o.step = 1'b1;
      end
      ST_REPORT: begin
        result_valid_o = !status_i.cmp_pending;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/core/range_predecessor_query_unit.sv -----
// Top level of the range predecessor query unit: controller plus datapath.
// Depends on rpq_pkg, rpq_ctrl and rpq_datapath.
//
//   channel   handshake                 payload
//   request   start_i / busy_o          req_type_i position_i value_i
//                                       range_low_i range_high_i limit_i
//   result    result_valid_o (strobe)   best_position_o found_o
//
// A load is written at the accepting edge and busy_o stays low. A query of n
// positions after clamping reads one table entry per cycle and passes through
// the states check, scan and report before its result strobe (an empty range
// skips the scan); busy_o is high until the strobe cycle ends. Reset clears
// controller state and the result registers only; the table holds no value until
// loaded. The receiver cannot stall: each result is shown for one cycle.
module range_predecessor_query_unit import rpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [POS_W-1:0]      range_low_i,
  input  logic [POS_W-1:0]      range_high_i,
  input  logic [VALUE_BITS-1:0] limit_i,
  output logic                  result_valid_o,
  output logic [POS_W-1:0]      best_position_o,
  output logic                  found_o
);

  rpq_cmd_t    cmd;
  rpq_status_t status;
  logic        load_we;

  rpq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_type_i     (req_type_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .load_we_o      (load_we),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  rpq_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_we_i       (load_we),
    .position_i      (position_i),
    .value_i         (value_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .limit_i         (limit_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .best_position_o (best_position_o),
    .found_o         (found_o)
  );

endmodule
